// ===== rtl/cartesian_to_spherical_macros.svh =====
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// antecedent implies consequent on the same edge
`define CTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never true outside reset
`define CTS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
package cts_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 32;
  localparam int unsigned ANGLE_WIDTH_DEF  = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 32;
  localparam int unsigned DW = 64;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

  typedef logic [DW-1:0] word_t;

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // arctangent of 2^-i in units of 2^-64 turn
  function automatic logic [63:0] atan_turn(input int unsigned i);
    logic [63:0]  a;
    logic [63:0]  term;
    logic [127:0] prod;
    int unsigned  e;
    a = '0;
    if (i == 0) begin
      return 64'h1 << 61;
    end
    for (int unsigned j = 0; j < 64; j++) begin
      e = i * (2 * j + 1);
      if (e <= 63) begin
        term = udiv64(64'h1 << (63 - e), 64'(2 * j + 1));
        a = j[0] ? a - term : a + term;
      end
    end
    prod = 128'(a) * 128'(INV_TWO_PI_Q64);
    return prod[126:63];
  endfunction

  // Q1.63 inverse CORDIC gain
  function automatic logic [63:0] gain_q63(input int unsigned steps);
    logic [63:0]  prod;
    logic [63:0]  k;
    logic [63:0]  t;
    logic [127:0] sq;
    logic [127:0] pp;
    prod = 64'h1 << 62;
    k = '0;
    for (int unsigned i = 0; i < steps; i++) begin
      if (2 * i < 64) begin
        prod = prod + (prod >> (2 * i));
      end
    end
    for (int b = 63; b >= 0; b--) begin
      t = k | (64'h1 << b);
      sq = 128'(t) * 128'(t);
      pp = 128'(sq[127:64]) * 128'(prod);
      if (pp[127:64] <= (64'h1 << 60)) begin
        k = t;
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/cts_cordic_stage.sv =====
module cts_cordic_stage #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cts_pkg::word_t    x_i,
  input  cts_pkg::word_t    y_i,
  input  cts_pkg::word_t    ang_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output cts_pkg::word_t    x_o,
  output cts_pkg::word_t    y_o,
  output cts_pkg::word_t    ang_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam cts_pkg::word_t ATAN = cts_pkg::atan_turn(IDX);

  logic           valid_q;
  cts_pkg::word_t x_q, y_q, ang_q, x_d, y_d, ang_d, dx, dy;
  logic [TAG_W-1:0] tag_q;

  always_comb begin
    dx = cts_pkg::word_t'($signed(y_i) >>> IDX);
    dy = cts_pkg::word_t'($signed(x_i) >>> IDX);
    if (y_i[cts_pkg::DW-1]) begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - ATAN;
    end else begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
    tag_q <= tag_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;
  assign tag_o   = tag_q;

endmodule

// ===== rtl/cts_gain_mul.sv =====
module cts_gain_mul #(
  parameter int unsigned STEPS = cts_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cts_pkg::word_t    v_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output cts_pkg::word_t    v_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam cts_pkg::word_t GAIN = cts_pkg::gain_q63(STEPS);

  logic [1:0]       valid_q;
  logic [63:0]      p00_q, p01_q, p10_q, p11_q;
  logic [TAG_W-1:0] tag0_q, tag1_q;
  logic [127:0]     full;
  cts_pkg::word_t   v_q;

  assign full = {p11_q, 64'h0} + {32'h0, p01_q, 32'h0} + {32'h0, p10_q, 32'h0}
              + {64'h0, p00_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p00_q  <= 64'(v_i[31:0])  * 64'(GAIN[31:0]);
    p01_q  <= 64'(v_i[31:0])  * 64'(GAIN[63:32]);
    p10_q  <= 64'(v_i[63:32]) * 64'(GAIN[31:0]);
    p11_q  <= 64'(v_i[63:32]) * 64'(GAIN[63:32]);
    tag0_q <= tag_i;
    v_q    <= full[126:63];
    tag1_q <= tag0_q;
  end

  assign valid_o = valid_q[1];
  assign v_o     = v_q;
  assign tag_o   = tag1_q;

endmodule

// ===== rtl/cartesian_to_spherical.sv =====
// channel  dir  handshake           fields
// command  in   start_i / busy_o    pos_x_i pos_y_i pos_z_i
// result   out  done_o (1 cycle)    longitude_o latitude_o radius_o zero_vector_o
//
// One item per cycle; two vectoring passes of one stage per step, two
// 2-stage gain multipliers and the in/out regs lie between start_i and done_o.
// busy_o is always low; the result side cannot stall, so the pipe never stops.
// Reset clears only the valid bits.
`include "cartesian_to_spherical_macros.svh"

module cartesian_to_spherical #(
  parameter int unsigned COORD_WIDTH  = cts_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH  = cts_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = cts_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [COORD_WIDTH-1:0] pos_x_i,
  input  logic [COORD_WIDTH-1:0] pos_y_i,
  input  logic [COORD_WIDTH-1:0] pos_z_i,
  output logic                   done_o,
  output logic [ANGLE_WIDTH-1:0] longitude_o,
  output logic [ANGLE_WIDTH-1:0] latitude_o,
  output logic [COORD_WIDTH-1:0] radius_o,
  output logic                   zero_vector_o
);

  localparam int unsigned DW    = cts_pkg::DW;
  localparam int unsigned GUARD = 60 - COORD_WIDTH;
  localparam int unsigned T1_W  = 2 + DW;
  localparam int unsigned T2_W  = 1 + ANGLE_WIDTH;
  localparam int unsigned T3_W  = 1 + 2 * ANGLE_WIDTH;
  localparam cts_pkg::word_t HALF = cts_pkg::word_t'(1) << (63 - ANGLE_WIDTH);
  localparam logic signed [ANGLE_WIDTH-1:0] LIM =
    ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

  // input register
  logic           in_valid_q;
  cts_pkg::word_t in_x_q, in_y_q, in_z_q, in_ang_q;
  logic           in_zero_q, in_flat_q;
  cts_pkg::word_t ex, ey, ez;

  assign busy_o = 1'b0;
  assign ex = cts_pkg::word_t'($signed(pos_x_i)) << GUARD;
  assign ey = cts_pkg::word_t'($signed(pos_y_i)) << GUARD;
  assign ez = cts_pkg::word_t'($signed(pos_z_i)) << GUARD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_flat_q <= (pos_x_i == '0) && (pos_y_i == '0);
    in_zero_q <= (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0);
    in_z_q    <= ez;
    if (ex[DW-1]) begin
      in_x_q   <= '0 - ex;
      in_y_q   <= '0 - ey;
      in_ang_q <= cts_pkg::word_t'(1) << 63;
    end else begin
      in_x_q   <= ex;
      in_y_q   <= ey;
      in_ang_q <= '0;
    end
  end

  // pass 1: atan2(y, x)
  logic           v1 [CORDIC_STEPS+1];
  cts_pkg::word_t x1 [CORDIC_STEPS+1];
  cts_pkg::word_t y1 [CORDIC_STEPS+1];
  cts_pkg::word_t a1 [CORDIC_STEPS+1];
  logic [T1_W-1:0] t1 [CORDIC_STEPS+1];

  assign v1[0] = in_valid_q;
  assign x1[0] = in_x_q;
  assign y1[0] = in_y_q;
  assign a1[0] = in_ang_q;
  assign t1[0] = {in_zero_q, in_flat_q, in_z_q};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pass1
    cts_cordic_stage #(.IDX(i), .TAG_W(T1_W)) u_stage (
      .clk_i, .rst_ni,
      .valid_i(v1[i]), .x_i(x1[i]), .y_i(y1[i]), .ang_i(a1[i]), .tag_i(t1[i]),
      .valid_o(v1[i+1]), .x_o(x1[i+1]), .y_o(y1[i+1]), .ang_o(a1[i+1]),
      .tag_o(t1[i+1])
    );
  end

  cts_pkg::word_t lon_sum;
  logic [ANGLE_WIDTH-1:0] lon1;
  logic           flat1;
  assign flat1   = t1[CORDIC_STEPS][DW];
  assign lon_sum = a1[CORDIC_STEPS] + HALF;
  assign lon1    = flat1 ? '0 : lon_sum[DW-1 -: ANGLE_WIDTH];

  logic           g1_valid;
  cts_pkg::word_t g1_p;
  logic [T1_W+ANGLE_WIDTH-1:0] g1_tag;

  cts_gain_mul #(.STEPS(CORDIC_STEPS), .TAG_W(T1_W + ANGLE_WIDTH)) u_gain1 (
    .clk_i, .rst_ni,
    .valid_i(v1[CORDIC_STEPS]),
    .v_i(flat1 ? '0 : x1[CORDIC_STEPS]),
    .tag_i({t1[CORDIC_STEPS], lon1}),
    .valid_o(g1_valid), .v_o(g1_p), .tag_o(g1_tag)
  );

  // pass 2: atan2(z, planar length)
  logic           v2 [CORDIC_STEPS+1];
  cts_pkg::word_t x2 [CORDIC_STEPS+1];
  cts_pkg::word_t y2 [CORDIC_STEPS+1];
  cts_pkg::word_t a2 [CORDIC_STEPS+1];
  logic [T2_W-1:0] t2 [CORDIC_STEPS+1];

  assign v2[0] = g1_valid;
  assign x2[0] = g1_p;
  assign y2[0] = g1_tag[ANGLE_WIDTH +: DW];
  assign a2[0] = '0;
  assign t2[0] = {g1_tag[T1_W+ANGLE_WIDTH-1], g1_tag[ANGLE_WIDTH-1:0]};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pass2
    cts_cordic_stage #(.IDX(i), .TAG_W(T2_W)) u_stage (
      .clk_i, .rst_ni,
      .valid_i(v2[i]), .x_i(x2[i]), .y_i(y2[i]), .ang_i(a2[i]), .tag_i(t2[i]),
      .valid_o(v2[i+1]), .x_o(x2[i+1]), .y_o(y2[i+1]), .ang_o(a2[i+1]),
      .tag_o(t2[i+1])
    );
  end

  cts_pkg::word_t lat_sum;
  logic signed [ANGLE_WIDTH-1:0] lat_raw, lat2;
  assign lat_sum = a2[CORDIC_STEPS] + HALF;
  assign lat_raw = lat_sum[DW-1 -: ANGLE_WIDTH];

  always_comb begin
    if (lat_raw > LIM) begin
      lat2 = LIM;
    end else if (lat_raw < -LIM) begin
      lat2 = -LIM;
    end else begin
      lat2 = lat_raw;
    end
  end

  logic           g2_valid;
  cts_pkg::word_t g2_r;
  logic [T3_W-1:0] g2_tag;

  cts_gain_mul #(.STEPS(CORDIC_STEPS), .TAG_W(T3_W)) u_gain2 (
    .clk_i, .rst_ni,
    .valid_i(v2[CORDIC_STEPS]),
    .v_i(x2[CORDIC_STEPS]),
    .tag_i({t2[CORDIC_STEPS], lat2}),
    .valid_o(g2_valid), .v_o(g2_r), .tag_o(g2_tag)
  );

  // rounding, clamping, output register
  cts_pkg::word_t r_sum;
  logic [DW-GUARD-1:0] r_full;
  logic [COORD_WIDTH-1:0] r_clamp;
  logic zero3;
  assign r_sum   = g2_r + (cts_pkg::word_t'(1) << (GUARD - 1));
  assign r_full  = r_sum[DW-1:GUARD];
  assign r_clamp = (r_full[DW-GUARD-1:COORD_WIDTH] != '0) ? '1 : r_full[COORD_WIDTH-1:0];
  assign zero3   = g2_tag[T3_W-1];

  logic done_q;
  logic [ANGLE_WIDTH-1:0] lon_q, lat_q;
  logic [COORD_WIDTH-1:0] rad_q;
  logic zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= g2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero3;
    lon_q  <= zero3 ? '0 : g2_tag[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
    lat_q  <= zero3 ? '0 : g2_tag[ANGLE_WIDTH-1:0];
    rad_q  <= zero3 ? '0 : r_clamp;
  end

  assign done_o        = done_q;
  assign longitude_o   = lon_q;
  assign latitude_o    = lat_q;
  assign radius_o      = rad_q;
  assign zero_vector_o = zero_q;

  `CTS_ASSERT_NEVER(a_never_busy, busy_o, "busy raised")
  `CTS_ASSERT_IMP(a_zero_out, done_o && zero_vector_o,
    longitude_o == '0 && latitude_o == '0 && radius_o == '0, "zero vector not zeroed")
  `CTS_ASSERT_IMP(a_lat_hi, done_o, $signed(latitude_o) <= LIM, "latitude above limit")
  `CTS_ASSERT_IMP(a_lat_lo, done_o, $signed(latitude_o) >= -LIM, "latitude below limit")

endmodule
